// File: src/sd_spi_command_transaction_assert.svh
// Assertion macros used by the SD SPI command transaction back end.
`ifndef SD_SPI_COMMAND_TRANSACTION_ASSERT_SVH
`define SD_SPI_COMMAND_TRANSACTION_ASSERT_SVH
`ifndef SYNTHESIS
`define SDSPI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");
`define SDSPI_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define SDSPI_ASSERT(lbl, prop)
`define SDSPI_ASSERT_NEVER(lbl, expr)
`endif
`endif

// File: src/sdspi_pkg.sv
// Types, codes and constants of the SD SPI command transaction block.
`timescale 1ns / 1ps
package sdspi_pkg;

  typedef enum logic [1:0] {
    OpStart     = 2'd0,
    OpExchanged = 2'd1,
    OpRelease   = 2'd2,
    OpNone      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PhIdle  = 3'd0,
    PhLead  = 3'd1,
    PhFrame = 3'd2,
    PhSkip  = 3'd3,
    PhPoll  = 3'd4,
    PhRelA  = 3'd5,
    PhRelB  = 3'd6
  } phase_e;

  localparam logic [7:0] IdleByte   = 8'hFF;
  localparam logic [1:0] StartBits  = 2'b01;
  localparam logic [6:0] Crc7Poly   = 7'h09;
  localparam logic       CrcEndBit  = 1'b1;
  localparam logic [5:0] StopCmd    = 6'd12;
  localparam logic [2:0] LastFrame  = 3'd6;
  localparam int         MsgBits    = 40;

  typedef struct packed {
    op_e         op;
    logic [5:0]  cmd;
    logic [31:0] arg;
    logic [6:0]  crc;
    logic [15:0] polls;
    logic [7:0]  rx;
  } item_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       select_low;
    logic       done_res;
    logic [7:0] response;
    logic       timed_out;
  } res_t;

  // CRC7 contribution of a single set message bit; the code is linear with a zero seed.
  function automatic logic [6:0] crc7_col(input int unsigned pos);
    logic [6:0] crc;
    logic       fb;
    crc = '0;
    for (int b = MsgBits - 1; b >= 0; b--) begin
      fb  = (b == int'(pos)) ^ crc[6];
      crc = {crc[5:0], 1'b0};
      if (fb) begin
        crc = crc ^ Crc7Poly;
      end
    end
    return crc;
  endfunction

endpackage

// File: src/sdspi_queue.sv
// Small first-in first-out queue of packed words.
`timescale 1ns / 1ps
module sdspi_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = wr_i & ~full_o;
  assign rd_en   = rd_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({wr_en, rd_en})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end
endmodule

// File: src/sdspi_front.sv
// Front end: accepts host words, computes the command CRC7 and forms queue entries.
`timescale 1ns / 1ps
module sdspi_front import sdspi_pkg::*; (
  input  logic        push_i,
  input  logic        full_i,
  input  logic [1:0]  opcode_i,
  input  logic [5:0]  command_index_i,
  input  logic [31:0] command_arg_i,
  input  logic [7:0]  received_byte_i,
  input  logic [15:0] max_tries_i,
  output logic        wr_o,
  output item_t       item_o
);
  logic [MsgBits-1:0] msg;
  logic [6:0]         crc;

  assign msg = {StartBits, command_index_i, command_arg_i};

  always_comb begin
    crc = '0;
    for (int unsigned i = 0; i < MsgBits; i++) begin
      if (msg[i]) begin
        crc = crc ^ crc7_col(i);
      end
    end
  end

  assign wr_o         = push_i & ~full_i;
  assign item_o.op    = op_e'(opcode_i);
  assign item_o.cmd   = command_index_i;
  assign item_o.arg   = command_arg_i;
  assign item_o.crc   = crc;
  assign item_o.polls = max_tries_i;
  assign item_o.rx    = received_byte_i;
endmodule

// File: src/sdspi_back.sv
// Back end: command sequencer that turns each queued word into one result word.
`timescale 1ns / 1ps
module sdspi_back import sdspi_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  item_valid_i,
  input  item_t item_i,
  input  logic  res_full_i,
  output logic  take_o,
  output logic  res_wr_o,
  output res_t  res_o
);
  `include "sd_spi_command_transaction_assert.svh"

  phase_e      phase_q, phase_d;
  logic [2:0]  pos_q, pos_d;
  logic [6:0]  crc_q, crc_d;
  logic [5:0]  cmd_q, cmd_d;
  logic [31:0] arg_q, arg_d;
  logic [15:0] polls_q, polls_d;
  logic        sel_q, sel_d;
  res_t        res;

  assign take_o   = item_valid_i & ~res_full_i;
  assign res_wr_o = take_o;
  assign res_o    = res;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    crc_d   = crc_q;
    cmd_d   = cmd_q;
    arg_d   = arg_q;
    polls_d = polls_q;
    sel_d   = sel_q;
    res     = '0;
    if (take_o) begin
      unique case (item_i.op)
        OpStart: begin
          cmd_d   = item_i.cmd;
          arg_d   = item_i.arg;
          crc_d   = item_i.crc;
          polls_d = item_i.polls;
          pos_d   = '0;
          phase_d = PhLead;
          res.send_valid = 1'b1;
          res.send_byte  = IdleByte;
        end
        OpRelease: begin
          phase_d = PhRelA;
          res.send_valid = 1'b1;
          res.send_byte  = IdleByte;
        end
        OpNone: begin
        end
        OpExchanged: begin
          unique case (phase_q)
            PhLead: begin
              sel_d   = 1'b1;
              pos_d   = '0;
              phase_d = PhFrame;
              res.send_valid = 1'b1;
              res.send_byte  = IdleByte;
            end
            PhFrame: begin
              res.send_valid = 1'b1;
              if (pos_q < LastFrame) begin
                pos_d = pos_q + 1'b1;
                unique case (pos_d)
                  3'd1:    res.send_byte = {StartBits, cmd_q};
                  3'd2:    res.send_byte = arg_q[31:24];
                  3'd3:    res.send_byte = arg_q[23:16];
                  3'd4:    res.send_byte = arg_q[15:8];
                  3'd5:    res.send_byte = arg_q[7:0];
                  3'd6:    res.send_byte = {crc_q, CrcEndBit};
                  default: res.send_byte = IdleByte;
                endcase
              end else begin
                phase_d = (cmd_q == StopCmd) ? PhSkip : PhPoll;
                res.send_byte = IdleByte;
              end
            end
            PhSkip: begin
              phase_d = PhPoll;
              res.send_valid = 1'b1;
              res.send_byte  = IdleByte;
            end
            PhPoll: begin
              if (item_i.rx != IdleByte) begin
                phase_d      = PhIdle;
                res.done_res = 1'b1;
                res.response = item_i.rx;
              end else if (polls_q == '0) begin
                phase_d       = PhIdle;
                res.done_res  = 1'b1;
                res.response  = IdleByte;
                res.timed_out = 1'b1;
              end else begin
                polls_d = polls_q - 1'b1;
                res.send_valid = 1'b1;
                res.send_byte  = IdleByte;
              end
            end
            PhRelA: begin
              sel_d   = 1'b0;
              phase_d = PhRelB;
              res.send_valid = 1'b1;
              res.send_byte  = IdleByte;
            end
            PhRelB: begin
              phase_d      = PhIdle;
              res.done_res = 1'b1;
            end
            default: begin
              phase_d = PhIdle;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
    res.select_low = sel_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      pos_q   <= '0;
      crc_q   <= '0;
      cmd_q   <= '0;
      arg_q   <= '0;
      polls_q <= '0;
      sel_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      cmd_q   <= cmd_d;
      arg_q   <= arg_d;
      polls_q <= polls_d;
      sel_q   <= sel_d;
    end
  end

  `SDSPI_ASSERT(a_frame_pos, (phase_q == PhFrame) |-> (pos_q <= LastFrame))
  `SDSPI_ASSERT(a_select_rise, $rose(sel_q) |-> ($past(phase_q) == PhLead))
  `SDSPI_ASSERT_NEVER(a_done_with_send, res_wr_o && res.done_res && res.send_valid)
  `SDSPI_ASSERT(a_poll_count,
                (phase_q == PhPoll && $past(phase_q) == PhPoll) |-> (polls_q <= $past(polls_q)))
endmodule

// File: src/sd_spi_command_transaction.sv
// Top level of the SD card SPI-mode command transaction engine.
// The host pushes words (opcode, command index, argument, received byte) into
// the push/full queue port: start a command, report a finished byte exchange,
// or release chip select. Each accepted word yields exactly one result word on
// the empty/pop port: the next byte to exchange with its chip-select level,
// or a done flag with the R1 response (0xFF with timed_out on timeout).
// The front computes the CRC7 of the start bits, command index and argument;
// the back sequences the frame and the response polling.
// Each word passes the inner queue and the sequencer into the output queue.
// Throughput: one word per cycle while the output queue has room.
// When the result side stalls, the output queue fills, then the inner queue,
// and full rises; nothing is dropped.
// Reset leaves both queues empty, the sequencer idle with chip select
// deasserted and max_tries at 1000. APB writes with paddr[2] low set max_tries;
// the user writes it only while the block is idle; not enforced by the block.
`timescale 1ns / 1ps
module sd_spi_command_transaction import sdspi_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [5:0]  command_index_i,
  input  logic [31:0] command_arg_i,
  input  logic [7:0]  received_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        send_valid_o,
  output logic [7:0]  send_byte_o,
  output logic        select_low_o,
  output logic        done_res_o,
  output logic [7:0]  response_o,
  output logic        timed_out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic RegMaxTries = 1'b0;

  logic [15:0] max_tries_q;
  logic        item_wr, item_full, item_empty, take, res_wr, res_full;
  item_t       item_in, item_out;
  res_t        res_in, res_out;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == RegMaxTries);
  assign prdata = (paddr[2] == RegMaxTries) ? {16'b0, max_tries_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tries_q <= 16'd1000;
    end else if (cfg_wr) begin
      max_tries_q <= pwdata[15:0];
    end
  end

  sdspi_front u_front (
    .push_i          (push),
    .full_i          (item_full),
    .opcode_i        (opcode_i),
    .command_index_i (command_index_i),
    .command_arg_i   (command_arg_i),
    .received_byte_i (received_byte_i),
    .max_tries_i     (max_tries_q),
    .wr_o            (item_wr),
    .item_o          (item_in)
  );

  assign full = item_full;

  sdspi_queue #(.Width($bits(item_t)), .Depth(QueueDepth)) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (item_wr),
    .wdata_i (item_in),
    .full_o  (item_full),
    .rd_i    (take),
    .rdata_o (item_out),
    .empty_o (item_empty)
  );

  sdspi_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (~item_empty),
    .item_i       (item_out),
    .res_full_i   (res_full),
    .take_o       (take),
    .res_wr_o     (res_wr),
    .res_o        (res_in)
  );

  sdspi_queue #(.Width($bits(res_t)), .Depth(QueueDepth)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_wr),
    .wdata_i (res_in),
    .full_o  (res_full),
    .rd_i    (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign send_valid_o = res_out.send_valid;
  assign send_byte_o  = res_out.send_byte;
  assign select_low_o = res_out.select_low;
  assign done_res_o   = res_out.done_res;
  assign response_o   = res_out.response;
  assign timed_out_o  = res_out.timed_out;
endmodule
